### src/framed_command_packet_parser_assert.svh
// assertion macros shared by the parser checker
`ifndef FRAMED_COMMAND_PACKET_PARSER_ASSERT_SVH
`define FRAMED_COMMAND_PACKET_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FCPP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FCPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fcpp_pkg.sv
// shared types and constants for the framed command packet parser
package fcpp_pkg;

	localparam int unsigned LEN_W   = 16;
	localparam int unsigned TIMER_W = 16;

	localparam logic [7:0] HDR_S     = 8'h53;
	localparam logic [7:0] HDR_C     = 8'h43;
	localparam logic [7:0] HDR_P     = 8'h50;
	localparam logic [7:0] HDR_A     = 8'h41;
	localparam logic [7:0] HDR_COLON = 8'h3A;

	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd100;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_C       = 4'd1,
		PH_P       = 4'd2,
		PH_A       = 4'd3,
		PH_COLON   = 4'd4,
		PH_LEN_LO  = 4'd5,
		PH_LEN_HI  = 4'd6,
		PH_CMD     = 4'd7,
		PH_PAYLOAD = 4'd8
	} phase_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] command;
		logic [7:0] payload;
		logic       last;
	} result_t;

endpackage

### src/fcpp_core.sv
// frame state machine: header hunt, length, command, payload and timeout
module fcpp_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                mode,
	input  logic [7:0]                          rx_byte,
	input  logic [fcpp_pkg::TIMER_W-1:0]        timeout_ticks,
	output fcpp_pkg::result_t                   result
);
	import fcpp_pkg::*;

	phase_t             phase_q, phase_d;
	logic [LEN_W-1:0]   remaining_q, remaining_d;
	logic [7:0]         command_q, command_d;
	logic [TIMER_W-1:0] timer_q, timer_d;
	logic               running_q, running_d;
	logic               expired;

	function automatic logic [7:0] hdr_expect(input phase_t ph);
		logic [7:0] r;
		r = HDR_COLON;
		unique case (ph)
			PH_C:    r = HDR_C;
			PH_P:    r = HDR_P;
			PH_A:    r = HDR_A;
			default: r = HDR_COLON;
		endcase
		return r;
	endfunction

	assign expired = running_q && (timer_q <= TIMER_W'(1));

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		command_d   = command_q;
		timer_d     = timer_q;
		running_d   = running_q;
		if (step) begin
			if (mode) begin
				if (expired) begin
					phase_d     = PH_HUNT;
					remaining_d = '0;
					command_d   = '0;
					timer_d     = '0;
					running_d   = 1'b0;
				end else if (running_q) begin
					timer_d = timer_q - TIMER_W'(1);
				end
			end else begin
				unique case (phase_q)
					PH_HUNT: begin
						if (rx_byte == HDR_S) begin
							timer_d   = timeout_ticks;
							running_d = 1'b1;
							phase_d   = PH_C;
						end
					end
					PH_C, PH_P, PH_A, PH_COLON: begin
						if (rx_byte == hdr_expect(phase_q)) begin
							phase_d = phase_t'(phase_q + 4'd1);
						end else begin
							phase_d     = PH_HUNT;
							remaining_d = '0;
							command_d   = '0;
							timer_d     = '0;
							running_d   = 1'b0;
						end
					end
					PH_LEN_LO: begin
						remaining_d = {8'h00, rx_byte};
						phase_d     = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						remaining_d = {rx_byte, remaining_q[7:0]};
						phase_d     = PH_CMD;
					end
					PH_CMD: begin
						if (remaining_q == '0) begin
							phase_d     = PH_HUNT;
							remaining_d = '0;
							command_d   = '0;
							timer_d     = '0;
							running_d   = 1'b0;
						end else begin
							command_d = rx_byte;
							phase_d   = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						if (remaining_q <= LEN_W'(1)) begin
							phase_d     = PH_HUNT;
							remaining_d = '0;
							command_d   = '0;
							timer_d     = '0;
							running_d   = 1'b0;
						end else begin
							remaining_d = remaining_q - LEN_W'(1);
						end
					end
					default: begin
						phase_d     = PH_HUNT;
						remaining_d = '0;
						command_d   = '0;
						timer_d     = '0;
						running_d   = 1'b0;
					end
				endcase
			end
		end
	end

	always_comb begin
		result = '0;
		if (step) begin
			if (mode) begin
				if (expired) begin
					result.valid   = 1'b1;
					result.kind    = KIND_TIMEOUT;
					result.command = command_q;
					result.last    = 1'b1;
				end
			end else begin
				unique case (phase_q)
					PH_CMD: begin
						if (remaining_q == '0) begin
							result.valid   = 1'b1;
							result.kind    = KIND_EMPTY;
							result.command = rx_byte;
							result.last    = 1'b1;
						end
					end
					PH_PAYLOAD: begin
						result.valid   = 1'b1;
						result.kind    = KIND_PAYLOAD;
						result.command = command_q;
						result.payload = rx_byte;
						result.last    = (remaining_q <= LEN_W'(1));
					end
					default: begin
						result.valid = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			remaining_q <= '0;
			command_q   <= '0;
			timer_q     <= '0;
			running_q   <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			command_q   <= command_d;
			timer_q     <= timer_d;
			running_q   <= running_d;
		end
	end

endmodule

### src/framed_command_packet_parser.sv
// top level: input register, frame state machine, output register
// an accepted item is held in the input register, its result in the output register
// throughput: one item per cycle unless the output stalls; each item is parsed in the
// single stage between the registers, and a stalled output holds one item in each
// reset: asynchronous, clears both stages and the frame state, timeout_ticks returns to 100
module framed_command_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] command, [15:8] payload_byte
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import fcpp_pkg::*;

	logic               valid_s1;
	logic               mode_s1;
	logic [7:0]         byte_s1;
	logic               valid_s2;
	kind_t              kind_s2;
	logic [7:0]         command_s2;
	logic [7:0]         payload_s2;
	logic               last_s2;
	logic [TIMER_W-1:0] timeout_q;
	logic               s2_free;
	logic               s1_adv;
	result_t            result;

	assign s2_free       = !valid_s2 || m_axis_tready;
	assign s1_adv        = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	fcpp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (s1_adv),
		.mode          (mode_s1),
		.rx_byte       (byte_s1),
		.timeout_ticks (timeout_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			kind_s2    <= result.kind;
			command_s2 <= result.command;
			payload_s2 <= result.payload;
			last_s2    <= result.last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {payload_s2, command_s2};
	assign m_axis_tuser  = kind_s2;
	assign m_axis_tlast  = last_s2;

endmodule

### src/fcpp_checker.sv
// port-level checker for the parser and its bind
`include "framed_command_packet_parser_assert.svh"

module fcpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import fcpp_pkg::*;

	`FCPP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output item changed")
	`FCPP_ASSERT_IMPL(a_status_last, m_axis_tvalid && (m_axis_tuser != KIND_PAYLOAD), m_axis_tlast, "empty or timeout item without last")
	`FCPP_ASSERT_IMPL(a_status_no_data, m_axis_tvalid && (m_axis_tuser != KIND_PAYLOAD), m_axis_tdata[15:8] == 8'h00, "non-payload item carries data")
	`FCPP_ASSERT_IMPL(a_out_from_in, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "output item without accepted input two cycles before")

endmodule

bind framed_command_packet_parser fcpp_checker u_fcpp_checker (.*);

### verif/tb_framed_command_packet_parser.sv
// self-checking testbench for the framed command packet parser, with a frame tracker class
module tb_framed_command_packet_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import fcpp_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 500;
	localparam int GAP_PCT      = 19;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [7:0] HEADER [5] = '{HDR_S, HDR_C, HDR_P, HDR_A, HDR_COLON};

	typedef struct {
		kind_t      kind;
		logic [7:0] command;
		logic [7:0] payload;
		logic       last;
	} parsed_item_t;

	class frame_tracker;
		logic [15:0]  timeout_ticks = TIMEOUT_RESET;
		phase_t       phase         = PH_HUNT;
		logic [15:0]  remaining     = '0;
		logic [7:0]   command       = '0;
		logic [15:0]  timer         = '0;
		bit           running       = 1'b0;
		parsed_item_t pending[$];
		int           errors        = 0;
		int           n_payload     = 0;
		int           n_empty       = 0;
		int           n_timeout     = 0;

		function void drop_frame();
			phase     = PH_HUNT;
			remaining = '0;
			command   = '0;
			timer     = '0;
			running   = 1'b0;
		endfunction

		function void expect_item(kind_t k, logic [7:0] c, logic [7:0] p, logic l);
			parsed_item_t r;
			r.kind    = k;
			r.command = c;
			r.payload = p;
			r.last    = l;
			pending.push_back(r);
		endfunction

		// one accepted input item
		function void take_item(logic mode, logic [7:0] b);
			logic [7:0] cmd;
			logic [7:0] want;
			cmd = command;
			if (mode == MODE_TICK) begin
				if (!running)
					return;
				if (timer <= 16'd1) begin
					drop_frame();
					expect_item(KIND_TIMEOUT, cmd, 8'h00, 1'b1);
				end else begin
					timer = timer - 16'd1;
				end
				return;
			end
			case (phase)
				PH_HUNT: begin
					if (b == HDR_S) begin
						timer   = timeout_ticks;
						running = 1'b1;
						phase   = PH_C;
					end
				end
				PH_C, PH_P, PH_A, PH_COLON: begin
					want = HEADER[phase];
					if (b == want)
						phase = phase_t'(phase + 4'd1);
					else
						drop_frame();
				end
				PH_LEN_LO: begin
					remaining = {8'h00, b};
					phase     = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					remaining[15:8] = b;
					phase           = PH_CMD;
				end
				PH_CMD: begin
					command = b;
					if (remaining == 16'd0) begin
						drop_frame();
						expect_item(KIND_EMPTY, b, 8'h00, 1'b1);
					end else begin
						phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (remaining <= 16'd1) begin
						drop_frame();
						expect_item(KIND_PAYLOAD, cmd, b, 1'b1);
					end else begin
						remaining = remaining - 16'd1;
						expect_item(KIND_PAYLOAD, cmd, b, 1'b0);
					end
				end
				default: drop_frame();
			endcase
		endfunction

		function void match_result(logic [1:0] k, logic [7:0] c, logic [7:0] p, logic l);
			parsed_item_t r;
			if (pending.size() == 0) begin
				$error("unexpected result: kind %0d command %0h payload %0h last %0b", k, c, p, l);
				errors++;
				return;
			end
			r = pending.pop_front();
			case (r.kind)
				KIND_PAYLOAD: n_payload++;
				KIND_EMPTY:   n_empty++;
				default:      n_timeout++;
			endcase
			if (k !== r.kind) begin
				$error("kind: expected %0d, got %0d", r.kind, k);
				errors++;
			end
			if (c !== r.command) begin
				$error("command: expected %0h, got %0h", r.command, c);
				errors++;
			end
			if (p !== r.payload) begin
				$error("payload_byte: expected %0h, got %0h", r.payload, p);
				errors++;
			end
			if (l !== r.last) begin
				$error("last: expected %0b, got %0b", r.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic [0:0]  s_axis_tuser;   // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;   // [7:0] command, [15:8] payload_byte
	logic [1:0]  m_axis_tuser;   // [1:0] kind
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	frame_tracker tracker;
	bit           no_gaps    = 1'b0;
	int unsigned  items_sent = 0;
	int unsigned  cycles     = 0;

	framed_command_packet_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic bit take_gap();
		return !no_gaps && ($urandom_range(0, 99) < GAP_PCT);
	endfunction

	always @(negedge clk)
		m_axis_tready <= !take_gap();

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.match_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
				m_axis_tlast);
	end

	// called and returns just after a falling edge
	task automatic send_item(input logic mode, input logic [7:0] b);
		while (take_gap()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_item(mode, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] len, input logic [7:0] cmd,
			input int unsigned n_payload, input int unsigned tick_pct);
		logic [7:0] bytes[$];
		bytes = '{HDR_S, HDR_C, HDR_P, HDR_A, HDR_COLON, len[7:0], len[15:8], cmd};
		repeat (n_payload) bytes.push_back(8'($urandom));
		foreach (bytes[i]) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_item(MODE_TICK, 8'($urandom));
			send_item(MODE_BYTE, bytes[i]);
		end
	endtask

	// sender holds off until every expected item is out and the pipeline is empty
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] ticks);
		cfg_valid <= 1'b1;
		cfg_data  <= ticks;
		do @(posedge clk); while (!cfg_ready);
		tracker.timeout_ticks = ticks;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned sel;
		int unsigned k;
		int unsigned phase_end;
		logic [15:0] len;
		logic [7:0]  wrong;
		logic [15:0] phase_timeout [4];

		tracker       = new;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// tick and stray byte while hunting, then a header broken by a second 'S'
		send_item(MODE_TICK, 8'hFF);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, HDR_S);
		send_item(MODE_BYTE, HDR_C);
		send_item(MODE_BYTE, HDR_S);
		send_item(MODE_BYTE, HDR_C);
		send_item(MODE_BYTE, HDR_P);
		send_frame(16'h0000, 8'hFF, 0, 0);
		send_frame(16'h0001, 8'h00, 1, 0);
		wait_idle();
		write_timeout(16'd1);
		send_item(MODE_BYTE, HDR_S);
		send_item(MODE_TICK, 8'h00);

		phase_timeout = '{16'hFFFF, 16'($urandom_range(2, 12)), 16'($urandom_range(13, 400)),
			16'd1};
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			write_timeout(phase_timeout[ph]);
			no_gaps   = (ph == 2);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				sel = $urandom_range(0, 99);
				if (sel < 55) begin
					k = $urandom_range(0, 99);
					if (k < 12)
						len = 16'd0;
					else if (k < 80)
						len = 16'($urandom_range(1, 6));
					else if (k < 97 || tracker.timeout_ticks > 16'd400)
						len = 16'($urandom_range(7, 40));
					else
						len = {8'($urandom_range(1, 255)), 8'($urandom)};
					if (len > 16'd40) begin
						// long frame cut short, left to expire
						send_frame(len, 8'($urandom), $urandom_range(0, 20), 4);
						while (tracker.running)
							send_item(MODE_TICK, 8'($urandom));
					end else begin
						send_frame(len, 8'($urandom), len, $urandom_range(0, 8));
					end
				end else if (sel < 70) begin
					k = $urandom_range(1, 4);
					for (int i = 0; i < k; i++)
						send_item(MODE_BYTE, HEADER[i]);
					if ($urandom_range(0, 2) == 0)
						wrong = HDR_S;
					else
						do wrong = 8'($urandom); while (wrong == HEADER[k]);
					send_item(MODE_BYTE, wrong);
				end else if (sel < 85) begin
					repeat ($urandom_range(1, 6)) send_item(MODE_BYTE, 8'($urandom));
				end else begin
					repeat ($urandom_range(1, 30)) send_item(MODE_TICK, 8'($urandom));
				end
			end
		end
		no_gaps = 1'b0;
		wait_idle();

		$display("%0d input items over five timeout settings", items_sent);
		$display("results seen: %0d payload, %0d empty frame, %0d timeout",
			tracker.n_payload, tracker.n_empty, tracker.n_timeout);
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
